>>> design/apr_pkg.sv
// Shared types, constants and colour functions for the attribute pixel decoder.
package apr_pkg;

	localparam int NumPixels = 8;

	typedef logic [23:0] pixel_t;
	typedef logic [7:0]  level_t;
	typedef logic [1:0]  mode_t;
	typedef logic [2:0]  border_sel_t;

	localparam mode_t MODE_SINGLE  = 2'd0;
	localparam mode_t MODE_AVERAGE = 2'd1;
	localparam mode_t MODE_BORDER  = 2'd2;

	localparam int BRIGHT_POS = 6;

	localparam level_t LEVEL_NORMAL = 8'hCD;
	localparam level_t LEVEL_BRIGHT = 8'hFF;

	localparam border_sel_t SEL_ZZ = 3'd0;
	localparam border_sel_t SEL_NN = 3'd1;
	localparam border_sel_t SEL_BB = 3'd2;
	localparam border_sel_t SEL_ZN = 3'd3;
	localparam border_sel_t SEL_NB = 3'd4;
	localparam border_sel_t SEL_ZB = 3'd5;

	function automatic level_t border_level(input border_sel_t sel);
		level_t lvl;
		case (sel)
			SEL_ZZ:  lvl = 8'h00;
			SEL_NN:  lvl = 8'h76;
			SEL_BB:  lvl = 8'hCD;
			SEL_ZN:  lvl = 8'hE9;
			SEL_NB:  lvl = 8'hFF;
			SEL_ZB:  lvl = 8'h9F;
			default: lvl = 8'h00;
		endcase
		return lvl;
	endfunction

	// index bit 0 blue, bit 1 red, bit 2 green
	function automatic pixel_t attr_colour(input logic bit_set, input logic [7:0] attr);
		logic [2:0] idx;
		level_t lvl;
		idx = bit_set ? attr[2:0] : attr[5:3];
		lvl = attr[BRIGHT_POS] ? LEVEL_BRIGHT : LEVEL_NORMAL;
		return {(idx[1] ? lvl : 8'h00), (idx[2] ? lvl : 8'h00), (idx[0] ? lvl : 8'h00)};
	endfunction

endpackage

>>> design/apr_in_if.sv
// Input channel: bitmap bytes and attributes with valid/ready.
interface apr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixels_a;
	logic [7:0] attr_a;
	logic [7:0] pixels_b;
	logic [7:0] attr_b;

	modport source(output valid, output pixels_a, output attr_a, output pixels_b,
		output attr_b, input ready);
	modport sink(input valid, input pixels_a, input attr_a, input pixels_b,
		input attr_b, output ready);
endinterface

>>> design/apr_out_if.sv
// Output channel: eight RGB888 pixels with valid/ready.
interface apr_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_0;
	logic [23:0] pixel_1;
	logic [23:0] pixel_2;
	logic [23:0] pixel_3;
	logic [23:0] pixel_4;
	logic [23:0] pixel_5;
	logic [23:0] pixel_6;
	logic [23:0] pixel_7;

	modport source(output valid, output pixel_0, output pixel_1, output pixel_2,
		output pixel_3, output pixel_4, output pixel_5, output pixel_6,
		output pixel_7, input ready);
	modport sink(input valid, input pixel_0, input pixel_1, input pixel_2,
		input pixel_3, input pixel_4, input pixel_5, input pixel_6,
		input pixel_7, output ready);
endinterface

>>> design/apr_lane.sv
// One pixel lane: ink/paper colour lookup, optionally averaged over two frames.
module apr_lane import apr_pkg::*; (
	input  logic       bit_a,
	input  logic [7:0] attr_a,
	input  logic       bit_b,
	input  logic [7:0] attr_b,
	input  logic       average,
	output pixel_t     colour
);

	pixel_t     col_a;
	pixel_t     col_b;
	logic [8:0] sum_r;
	logic [8:0] sum_g;
	logic [8:0] sum_b;

	always_comb begin
		col_a = attr_colour(bit_a, attr_a);
		col_b = attr_colour(bit_b, attr_b);
		sum_r = {1'b0, col_a[23:16]} + {1'b0, col_b[23:16]};
		sum_g = {1'b0, col_a[15:8]} + {1'b0, col_b[15:8]};
		sum_b = {1'b0, col_a[7:0]} + {1'b0, col_b[7:0]};
		if (average) begin
			colour = {sum_r[8:1], sum_g[8:1], sum_b[8:1]};
		end else begin
			colour = col_a;
		end
	end

endmodule

>>> design/apr_border.sv
// Merged border colour from two attributes' ink and bright classes.
module apr_border import apr_pkg::*; (
	input  logic [7:0] attr_a,
	input  logic [7:0] attr_b,
	output pixel_t     colour
);

	logic        z0, z1, n0, n1, b0, b1;
	border_sel_t sel;
	level_t      lvl;
	logic [8:0]  sum_r;
	logic [8:0]  sum_g;
	logic [8:0]  sum_b;

	always_comb begin
		b0 = attr_a[BRIGHT_POS];
		b1 = attr_b[BRIGHT_POS];
		z0 = (attr_a[2:0] == 3'd0);
		z1 = (attr_b[2:0] == 3'd0);
		n0 = !z0 && !b0;
		n1 = !z1 && !b1;
		if (z0 && z1) begin
			sel = SEL_ZZ;
		end else if (n0 && n1) begin
			sel = SEL_NN;
		end else if (b0 && b1) begin
			sel = SEL_BB;
		end else if (z0 && n1) begin
			sel = SEL_ZN;
		end else if (n0 && b1) begin
			sel = SEL_NB;
		end else if (z0 && b1) begin
			sel = SEL_ZB;
		end else begin
			sel = SEL_ZZ;
		end
		lvl   = border_level(sel);
		sum_b = {1'b0, attr_a[0] ? lvl : 8'h00} + {1'b0, attr_b[0] ? lvl : 8'h00};
		sum_r = {1'b0, attr_a[1] ? lvl : 8'h00} + {1'b0, attr_b[1] ? lvl : 8'h00};
		sum_g = {1'b0, attr_a[2] ? lvl : 8'h00} + {1'b0, attr_b[2] ? lvl : 8'h00};
		colour = {sum_r[8:1], sum_g[8:1], sum_b[8:1]};
	end

endmodule

>>> design/apr_merge.sv
// Merge stage: picks lane or border colours and holds them in the output register.
module apr_merge import apr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  mode_t  mode,
	input  pixel_t lane_colour [NumPixels],
	input  pixel_t fill_colour,
	output logic   out_valid,
	input  logic   out_ready,
	output pixel_t pixel_q [NumPixels]
);

	logic valid_q;
	logic load;

	assign in_ready  = !valid_q || out_ready;
	assign load      = in_valid && in_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NumPixels; i++) begin
				pixel_q[i] <= (mode == MODE_BORDER) ? fill_colour : lane_colour[i];
			end
		end
	end

endmodule

>>> design/attribute_pixel_to_rgb.sv
// Attribute pixel decoder top level: eight lanes, border unit and output register.
//
// Input channel pix_in carries one bitmap byte and attribute (plus a second
// pair for averaging) per word; output channel pix_out carries eight RGB888
// pixels, pixel_0 leftmost. Both use valid/ready, a word moving when both
// are high.
// cfg_we/cfg_data write decode_mode: 0 single decode, 1 two-frame average,
// 2 border fill (3 acts as 0). Write only while no word is in flight.
// An accepted input word is registered and valid at the output in the next cycle.
// Throughput: one word per cycle while the receiver does not stall; eight
// lanes decode all pixels at once into the single output register.
// A stalled receiver holds the output word; pix_in.ready stays high
// while the register is empty or being drained in the same cycle.
// Reset clears the output valid flag and sets decode_mode to 0.
module attribute_pixel_to_rgb import apr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	apr_in_if.sink     pix_in,
	apr_out_if.source  pix_out
);

	mode_t  mode_q;
	pixel_t lane_colour [NumPixels];
	pixel_t fill_colour;
	pixel_t pixel_q [NumPixels];
	logic   average;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SINGLE;
		end else if (cfg_we) begin
			mode_q <= cfg_data;
		end
	end

	assign average = (mode_q == MODE_AVERAGE);

	for (genvar g = 0; g < NumPixels; g++) begin : g_lane
		apr_lane u_lane (
			.bit_a  (pix_in.pixels_a[NumPixels-1-g]),
			.attr_a (pix_in.attr_a),
			.bit_b  (pix_in.pixels_b[NumPixels-1-g]),
			.attr_b (pix_in.attr_b),
			.average(average),
			.colour (lane_colour[g])
		);
	end

	apr_border u_border (
		.attr_a(pix_in.attr_a),
		.attr_b(pix_in.attr_b),
		.colour(fill_colour)
	);

	apr_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pix_in.valid),
		.in_ready   (pix_in.ready),
		.mode       (mode_q),
		.lane_colour(lane_colour),
		.fill_colour(fill_colour),
		.out_valid  (pix_out.valid),
		.out_ready  (pix_out.ready),
		.pixel_q    (pixel_q)
	);

	assign pix_out.pixel_0 = pixel_q[0];
	assign pix_out.pixel_1 = pixel_q[1];
	assign pix_out.pixel_2 = pixel_q[2];
	assign pix_out.pixel_3 = pixel_q[3];
	assign pix_out.pixel_4 = pixel_q[4];
	assign pix_out.pixel_5 = pixel_q[5];
	assign pix_out.pixel_6 = pixel_q[6];
	assign pix_out.pixel_7 = pixel_q[7];

endmodule

>>> tb/sv/attribute_pixel_to_rgb_tb.sv
// Testbench for attribute_pixel_to_rgb: directed and random words checked against a local decoder.
module attribute_pixel_to_rgb_tb import apr_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 100000;
	localparam int MaxReports = 10;
	localparam int TailCycles = 4;
	localparam int RandomPerMode = 30;
	localparam mode_t MODE_UNDEFINED = 2'd3;
	localparam level_t BORDER_LEVELS [6] = '{8'h00, 8'h76, 8'hCD, 8'hE9, 8'hFF, 8'h9F};

	typedef struct packed {
		logic [7:0] pixels_a;
		logic [7:0] attr_a;
		logic [7:0] pixels_b;
		logic [7:0] attr_b;
	} word_t;

	typedef logic [NumPixels-1:0][23:0] row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_data;

	apr_in_if  pix_in ();
	apr_out_if pix_out ();

	attribute_pixel_to_rgb dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.pix_in   (pix_in),
		.pix_out  (pix_out)
	);

	mode_t decode_mode_now;
	row_t  rows_due [$];
	int    mismatches;
	int    send_idle_pct;
	int    recv_stall_pct;
	int    hold_cycles;
	int    cycle_count;

	function automatic pixel_t ink_paper_rgb(input logic ink, input logic [7:0] attr);
		logic [2:0] idx;
		level_t lvl;
		pixel_t rgb;
		idx = ink ? attr[2:0] : attr[5:3];
		lvl = attr[BRIGHT_POS] ? LEVEL_BRIGHT : LEVEL_NORMAL;
		rgb[23:16] = {8{idx[1]}} & lvl;
		rgb[15:8]  = {8{idx[2]}} & lvl;
		rgb[7:0]   = {8{idx[0]}} & lvl;
		return rgb;
	endfunction

	function automatic pixel_t mean_rgb(input pixel_t x, input pixel_t y);
		logic [8:0] total;
		pixel_t rgb;
		for (int k = 0; k < 3; k++) begin
			total = {1'b0, x[8*k +: 8]} + {1'b0, y[8*k +: 8]};
			rgb[8*k +: 8] = total[8:1];
		end
		return rgb;
	endfunction

	function automatic pixel_t border_rgb(input logic [7:0] a0, input logic [7:0] a1);
		logic z0, z1, b0, b1, n0, n1;
		level_t lvl;
		logic [8:0] r, g, b;
		z0 = a0[2:0] == 3'b000;
		z1 = a1[2:0] == 3'b000;
		b0 = a0[BRIGHT_POS];
		b1 = a1[BRIGHT_POS];
		n0 = !z0 && !b0;
		n1 = !z1 && !b1;
		lvl = 8'h00;
		if (z0 && z1)
			lvl = BORDER_LEVELS[SEL_ZZ];
		else if (n0 && n1)
			lvl = BORDER_LEVELS[SEL_NN];
		else if (b0 && b1)
			lvl = BORDER_LEVELS[SEL_BB];
		else if (z0 && n1)
			lvl = BORDER_LEVELS[SEL_ZN];
		else if (n0 && b1)
			lvl = BORDER_LEVELS[SEL_NB];
		else if (z0 && b1)
			lvl = BORDER_LEVELS[SEL_ZB];
		b = {1'b0, a0[0] ? lvl : 8'h00} + {1'b0, a1[0] ? lvl : 8'h00};
		r = {1'b0, a0[1] ? lvl : 8'h00} + {1'b0, a1[1] ? lvl : 8'h00};
		g = {1'b0, a0[2] ? lvl : 8'h00} + {1'b0, a1[2] ? lvl : 8'h00};
		return {r[8:1], g[8:1], b[8:1]};
	endfunction

	function automatic row_t decode_word(input word_t w);
		row_t row;
		for (int i = 0; i < NumPixels; i++) begin
			if (decode_mode_now == MODE_BORDER)
				row[i] = border_rgb(w.attr_a, w.attr_b);
			else if (decode_mode_now == MODE_AVERAGE)
				row[i] = mean_rgb(ink_paper_rgb(w.pixels_a[7-i], w.attr_a),
					ink_paper_rgb(w.pixels_b[7-i], w.attr_b));
			else
				row[i] = ink_paper_rgb(w.pixels_a[7-i], w.attr_a);
		end
		return row;
	endfunction

	function automatic word_t random_word();
		word_t w;
		w = word_t'($urandom);
		// keep zero ink common so every border class turns up
		if ($urandom_range(3) == 0)
			w.attr_a[2:0] = 3'b000;
		if ($urandom_range(3) == 0)
			w.attr_b[2:0] = 3'b000;
		return w;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("attribute_pixel_to_rgb: mismatch");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus a counted hold-off
	initial begin
		pix_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				pix_out.ready <= 1'b0;
				hold_cycles--;
			end else begin
				pix_out.ready <= $urandom_range(99) >= recv_stall_pct;
			end
		end
	end

	always @(posedge clk) begin : check_rows
		row_t got;
		row_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			got = {pix_out.pixel_7, pix_out.pixel_6, pix_out.pixel_5, pix_out.pixel_4,
				pix_out.pixel_3, pix_out.pixel_2, pix_out.pixel_1, pix_out.pixel_0};
			if (rows_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("unexpected word: got %h", got);
			end else begin
				want = rows_due.pop_front();
				for (int i = 0; i < NumPixels; i++) begin
					if (got[i] !== want[i]) begin
						mismatches++;
						if (mismatches <= MaxReports)
							$display("pixel_%0d: expected %h got %h", i, want[i], got[i]);
					end
				end
			end
		end
	end

	task automatic send_word(input word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in.valid    <= 1'b1;
		pix_in.pixels_a <= w.pixels_a;
		pix_in.attr_a   <= w.attr_a;
		pix_in.pixels_b <= w.pixels_b;
		pix_in.attr_b   <= w.attr_b;
		do
			@(posedge clk);
		while (!pix_in.ready);
		rows_due.insert(rows_due.size(), decode_word(w));
	endtask

	task automatic send_bytes(input logic [7:0] pa, input logic [7:0] aa,
		input logic [7:0] pb, input logic [7:0] ab);
		send_word('{pixels_a: pa, attr_a: aa, pixels_b: pb, attr_b: ab});
	endtask

	task automatic wait_drained();
		@(negedge clk);
		pix_in.valid <= 1'b0;
		while (rows_due.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	task automatic set_mode(input mode_t m);
		wait_drained();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= m;
		decode_mode_now = m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_mode();
		send_bytes(8'hA5, 8'h0E, 8'hFF, 8'h3F);
		send_bytes(8'h3C, 8'hB9, 8'h00, 8'h00);
		wait_drained();
	endtask

	task automatic test_single();
		set_mode(MODE_SINGLE);
		send_bytes(8'h00, 8'h00, 8'hFF, 8'hFF);
		send_bytes(8'hFF, 8'hFF, 8'h00, 8'h00);
		send_bytes(8'hA5, 8'h47, 8'h5A, 8'h12);
		send_bytes(8'h5A, 8'hB8, 8'h81, 8'h7E);
	endtask

	task automatic test_average();
		set_mode(MODE_AVERAGE);
		send_bytes(8'hF0, 8'h4F, 8'h0F, 8'h39);
		send_bytes(8'hFF, 8'hFF, 8'hFF, 8'h07);
		send_bytes(8'h00, 8'h00, 8'h00, 8'h00);
		send_bytes(8'h96, 8'h8A, 8'h69, 8'hF5);
	endtask

	task automatic test_border();
		set_mode(MODE_BORDER);
		send_bytes(8'hFF, 8'h00, 8'hFF, 8'h00);  // zero, zero
		send_bytes(8'h12, 8'h05, 8'h34, 8'h03);  // plain, plain
		send_bytes(8'h00, 8'h47, 8'hFF, 8'hC1);  // bright, bright
		send_bytes(8'h55, 8'h00, 8'hAA, 8'h07);  // zero, plain
		send_bytes(8'h00, 8'h02, 8'h00, 8'h46);  // plain, bright
		send_bytes(8'hC3, 8'h80, 8'h3C, 8'h45);  // zero, bright
		send_bytes(8'h00, 8'h40, 8'h00, 8'h40);  // zero and bright both sides
		send_bytes(8'h00, 8'h03, 8'h00, 8'h00);  // no class pair: black
		send_bytes(8'h00, 8'h47, 8'h00, 8'h03);
	endtask

	task automatic test_undefined_mode();
		set_mode(MODE_UNDEFINED);
		send_bytes(8'hA5, 8'h4E, 8'h0F, 8'h07);
		send_bytes(8'h0F, 8'h31, 8'hF0, 8'h00);
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct);
		mode_t modes [4];
		wait_drained();
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		modes = '{MODE_SINGLE, MODE_AVERAGE, MODE_BORDER, MODE_UNDEFINED};
		modes.shuffle();
		foreach (modes[k]) begin
			set_mode(modes[k]);
			repeat (RandomPerMode) send_word(random_word());
		end
	endtask

	task automatic test_backpressure();
		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_mode(MODE_AVERAGE);
		hold_cycles = 200;
		repeat (RandomPerMode) send_word(random_word());
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_data        = MODE_SINGLE;
		pix_in.valid    = 1'b0;
		pix_in.pixels_a = 8'h00;
		pix_in.attr_a   = 8'h00;
		pix_in.pixels_b = 8'h00;
		pix_in.attr_b   = 8'h00;
		decode_mode_now = MODE_SINGLE;
		mismatches      = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_cycles     = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_mode();
		test_single();
		test_average();
		test_border();
		test_undefined_mode();
		test_random(0, 0);
		test_random(85, 0);
		test_random(0, 85);
		test_random(36, 36);
		test_backpressure();

		wait_drained();
		if (mismatches == 0 && rows_due.size() == 0)
			$display("attribute_pixel_to_rgb: match");
		else
			$display("attribute_pixel_to_rgb: mismatch");
		$finish;
	end

endmodule
